[rtl/core/dqp_pkg.sv]
// ----------------------------------------------------------------------------
// DNS query parser package
// Shared constants, types and record builders for the DNS query parser.
// ----------------------------------------------------------------------------
package dqp_pkg;

  // Message store and pointer walk sizing.
  localparam int PACKET_BYTES     = 512;
  localparam int MAX_POINTER_HOPS = 16;
  localparam int ADDR_W           = $clog2(PACKET_BYTES);
  localparam int CNT_W            = $clog2(PACKET_BYTES + 1);
  localparam int HOP_W            = $clog2(MAX_POINTER_HOPS + 1);
  localparam int POS_W            = 15;

  // Item queue between the front and the back.
  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = 2;

  // Result queue inside the back.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;

  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [15:0] HEADER_LEN  = 16'd12;

  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_QUESTION = 2'd1,
    KIND_END      = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_TRUNC_KEPT     = 3'd1,
    ST_TRUNC_DROPPED  = 3'd2,
    ST_BAD_LABEL      = 3'd3,
    ST_BAD_PTR_KEPT   = 3'd4,
    ST_BAD_PTR_DROPPED = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_LHEAD,
    PH_LBODY,
    PH_PLOW,
    PH_QT_HI,
    PH_QT_LO,
    PH_QC_HI,
    PH_QC_LO,
    PH_WAIT
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WFETCH,
    BK_WCHECK,
    BK_WLOW
  } back_state_e;

  // One classified input byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic              store;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       pos;
  } item_t;

  // One result record.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic [15:0] word_e;
    logic        qr_bit;
    logic [3:0]  opcode;
    logic [3:0]  aa_tc_rd_ra;
    logic [2:0]  z_bits;
    logic [3:0]  rcode;
    status_e     status;
  } rec_t;

  // Builds an end record with the given status.
  function automatic rec_t end_rec(input status_e st);
    rec_t r;
    r        = '0;
    r.kind   = KIND_END;
    r.status = st;
    return r;
  endfunction

  // Builds a header record from the twelve header bytes, first byte on top.
  function automatic rec_t header_rec(input logic [95:0] hb);
    rec_t r;
    r             = '0;
    r.kind        = KIND_HEADER;
    r.word_a      = hb[95:80];
    r.word_b      = hb[63:48];
    r.word_c      = hb[47:32];
    r.word_d      = hb[31:16];
    r.word_e      = hb[15:0];
    r.qr_bit      = hb[79];
    r.opcode      = hb[78:75];
    r.aa_tc_rd_ra = hb[74:71];
    r.z_bits      = hb[70:68];
    r.rcode       = hb[67:64];
    r.status      = ST_OK;
    return r;
  endfunction

endpackage

[rtl/core/dqp_fifo.sv]
// ----------------------------------------------------------------------------
// DNS query parser item queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module dqp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dqp_pkg::item_t push_item_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dqp_pkg::item_t head_o
);
  import dqp_pkg::*;

  item_t               mem_q [IQ_DEPTH];
  logic [IQ_PTR_W-1:0] wp_q, rp_q;
  logic [IQ_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (IQ_PTR_W + 1)'(IQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rp_q];

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/dqp_front.sv]
// ----------------------------------------------------------------------------
// DNS query parser front
// Accepts message bytes, tracks the byte offset and classifies each item.
// ----------------------------------------------------------------------------
module dqp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  input  logic           full_i,
  output logic           push_o,
  output dqp_pkg::item_t item_o
);
  import dqp_pkg::*;

  logic [15:0] pos_q, pos_d;
  logic [15:0] pos_after;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // The offset saturates so that very long messages keep a stable length.
  always_comb begin
    pos_after = (pos_q == POS_MAX) ? pos_q : pos_q + 16'd1;
    pos_d     = last_byte_i ? '0 : pos_after;
    item_o.data  = data_byte_i;
    item_o.last  = last_byte_i;
    item_o.store = (pos_q < 16'(PACKET_BYTES));
    item_o.addr  = pos_q[ADDR_W-1:0];
    item_o.pos   = pos_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (push_o) begin
      pos_q <= pos_d;
    end
  end

endmodule

[rtl/core/dqp_back.sv]
// ----------------------------------------------------------------------------
// DNS query parser back
// Stores bytes, runs the header and question parser, walks compression
// pointers through the store and queues the result records.
// ----------------------------------------------------------------------------
module dqp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           hd_valid_i,
  input  dqp_pkg::item_t hd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dqp_pkg::rec_t  rec_o
);
  import dqp_pkg::*;

  // Message store.
  logic [7:0]        store_q [PACKET_BYTES];
  logic [7:0]        rdata_q;
  logic [ADDR_W-1:0] raddr;
  logic              mem_we;

  back_state_e       state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        acc_q, acc_d;
  logic [15:0]       ql_q, ql_d;
  logic [5:0]        lbl_q, lbl_d;
  logic [15:0]       qstart_q, qstart_d;
  logic [15:0]       qtype_q, qtype_d;
  logic [15:0]       wlen_q, wlen_d;
  logic [87:0]       hdr_q, hdr_d;
  logic              partial_q;
  logic [POS_W-1:0]  wpos_q, wpos_d;
  logic [HOP_W-1:0]  hops_q, hops_d;
  logic [5:0]        phi_q, phi_d;
  item_t             item_q, item_d;

  // Result queue.
  rec_t                oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] owp_q, orp_q;
  logic [OQ_PTR_W:0]   ocnt_q;

  logic             go, fin;
  item_t            cur;
  logic             main_v, end_v;
  rec_t             main_r;
  status_e          end_st;
  logic [CNT_W-1:0] limit;
  logic [POS_W-1:0] lim_x;
  logic [POS_W:0]   wsum;
  logic [HOP_W:0]   hop_n;
  logic [95:0]      hb;
  logic             push0, push1;
  rec_t             rec0, rec1;
  logic             opop;

  assign go          = (ocnt_q <= (OQ_PTR_W + 1)'(OQ_DEPTH - 2));
  assign opop        = out_valid_o && out_ready_i;
  assign out_valid_o = (ocnt_q != '0);
  assign rec_o       = oq_q[orp_q];

  // Parser, pointer walk and record selection.
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    ql_d     = ql_q;
    lbl_d    = lbl_q;
    qstart_d = qstart_q;
    qtype_d  = qtype_q;
    wlen_d   = wlen_q;
    hdr_d    = hdr_q;
    wpos_d   = wpos_q;
    hops_d   = hops_q;
    phi_d    = phi_q;
    item_d   = item_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    fin      = 1'b0;
    main_v   = 1'b0;
    main_r   = '0;
    end_v    = 1'b0;
    end_st   = ST_OK;
    raddr    = wpos_q[ADDR_W-1:0];
    cur      = (state_q == BK_IDLE) ? hd_i : item_q;
    hb       = {hdr_q, hd_i.data};
    limit    = (cur.pos >= 16'(PACKET_BYTES)) ? CNT_W'(PACKET_BYTES) : cur.pos[CNT_W-1:0];
    lim_x    = POS_W'(limit);
    wsum     = {1'b0, wpos_q} + (POS_W + 1)'(rdata_q[5:0]) + 1'b1;
    hop_n    = {1'b0, hops_q} + 1'b1;

    case (state_q)
      BK_IDLE: begin
        if (hd_valid_i && go) begin
          pop_o  = 1'b1;
          mem_we = hd_i.store;
          if (phase_q == PH_PLOW) begin
            // Second pointer byte: start the walk through the store.
            wpos_d  = POS_W'({acc_q[5:0], hd_i.data});
            hops_d  = HOP_W'(1);
            item_d  = hd_i;
            state_d = BK_WFETCH;
          end else begin
            fin = 1'b1;
            case (phase_q)
              PH_HEADER: begin
                hdr_d = hb[87:0];
                if (hd_i.pos == HEADER_LEN) begin
                  main_v = 1'b1;
                  main_r = header_rec(hb);
                  if (!hb[79] && (hb[63:48] != '0)) begin
                    ql_d     = hb[63:48];
                    qstart_d = hd_i.pos;
                    phase_d  = PH_LHEAD;
                  end else begin
                    end_v   = 1'b1;
                    end_st  = ST_OK;
                    phase_d = PH_WAIT;
                  end
                end
              end
              PH_LHEAD: begin
                if (hd_i.data[7:6] == 2'b00) begin
                  if (hd_i.data[5:0] == '0) begin
                    wlen_d  = hd_i.pos - qstart_q;
                    phase_d = PH_QT_HI;
                  end else begin
                    lbl_d   = hd_i.data[5:0];
                    phase_d = PH_LBODY;
                  end
                end else if (hd_i.data[7:6] == 2'b11) begin
                  acc_d   = {2'b00, hd_i.data[5:0]};
                  phase_d = PH_PLOW;
                end else begin
                  end_v   = 1'b1;
                  end_st  = ST_BAD_LABEL;
                  phase_d = PH_WAIT;
                end
              end
              PH_LBODY: begin
                lbl_d = lbl_q - 1'b1;
                if (lbl_q == 6'd1) begin
                  phase_d = PH_LHEAD;
                end
              end
              PH_QT_HI: begin
                acc_d   = hd_i.data;
                phase_d = PH_QT_LO;
              end
              PH_QT_LO: begin
                qtype_d = {acc_q, hd_i.data};
                phase_d = PH_QC_HI;
              end
              PH_QC_HI: begin
                acc_d   = hd_i.data;
                phase_d = PH_QC_LO;
              end
              PH_QC_LO: begin
                main_v        = 1'b1;
                main_r        = '0;
                main_r.kind   = KIND_QUESTION;
                main_r.word_a = qtype_q;
                main_r.word_b = {acc_q, hd_i.data};
                main_r.word_c = wlen_q;
                main_r.status = ST_OK;
                ql_d          = ql_q - 1'b1;
                if (ql_q == 16'd1) begin
                  end_v   = 1'b1;
                  end_st  = ST_OK;
                  phase_d = PH_WAIT;
                end else begin
                  qstart_d = hd_i.pos;
                  phase_d  = PH_LHEAD;
                end
              end
              default: begin
                phase_d = PH_WAIT;
              end
            endcase
          end
        end
      end
      BK_WFETCH: begin
        if (go) begin
          if (wpos_q >= lim_x) begin
            fin     = 1'b1;
            end_v   = 1'b1;
            end_st  = partial_q ? ST_BAD_PTR_KEPT : ST_BAD_PTR_DROPPED;
            phase_d = PH_WAIT;
            state_d = BK_IDLE;
          end else begin
            state_d = BK_WCHECK;
          end
        end
      end
      BK_WCHECK: begin
        if (go) begin
          if (rdata_q[7:6] == 2'b00) begin
            if (rdata_q[5:0] == '0) begin
              // Name ends in the store: the question continues in the stream.
              fin     = 1'b1;
              wlen_d  = item_q.pos - qstart_q;
              phase_d = PH_QT_HI;
              state_d = BK_IDLE;
            end else if (wsum > {1'b0, lim_x}) begin
              fin     = 1'b1;
              end_v   = 1'b1;
              end_st  = partial_q ? ST_BAD_PTR_KEPT : ST_BAD_PTR_DROPPED;
              phase_d = PH_WAIT;
              state_d = BK_IDLE;
            end else begin
              wpos_d  = wsum[POS_W-1:0];
              state_d = BK_WFETCH;
            end
          end else if (rdata_q[7:6] == 2'b11) begin
            if ((wpos_q + 1'b1) >= lim_x ||
                hop_n > (HOP_W + 1)'(MAX_POINTER_HOPS)) begin
              fin     = 1'b1;
              end_v   = 1'b1;
              end_st  = partial_q ? ST_BAD_PTR_KEPT : ST_BAD_PTR_DROPPED;
              phase_d = PH_WAIT;
              state_d = BK_IDLE;
            end else begin
              hops_d  = hop_n[HOP_W-1:0];
              phi_d   = rdata_q[5:0];
              raddr   = wpos_q[ADDR_W-1:0] + 1'b1;
              state_d = BK_WLOW;
            end
          end else begin
            fin     = 1'b1;
            end_v   = 1'b1;
            end_st  = ST_BAD_LABEL;
            phase_d = PH_WAIT;
            state_d = BK_IDLE;
          end
        end
      end
      BK_WLOW: begin
        wpos_d  = POS_W'({phi_q, rdata_q});
        state_d = BK_WFETCH;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    // End of message: close an open parse and clear the per-message state.
    if (fin && cur.last) begin
      if (phase_d != PH_WAIT) begin
        end_v  = 1'b1;
        end_st = partial_q ? ST_TRUNC_KEPT : ST_TRUNC_DROPPED;
      end
      phase_d  = PH_HEADER;
      acc_d    = '0;
      ql_d     = '0;
      lbl_d    = '0;
      qstart_d = '0;
      qtype_d  = '0;
      wlen_d   = '0;
    end

    // The record of the item goes first, its end record after it.
    push0 = main_v || end_v;
    push1 = main_v && end_v;
    rec0  = main_v ? main_r : end_rec(end_st);
    rec1  = end_rec(end_st);
  end

  // Store write and registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[hd_i.addr] <= hd_i.data;
    end
    rdata_q <= store_q[raddr];
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (push0) begin
      oq_q[owp_q] <= rec0;
    end
    if (push1) begin
      oq_q[owp_q + 1'b1] <= rec1;
    end
  end

  // Payload registers that need no reset.
  always_ff @(posedge clk_i) begin
    hdr_q  <= hdr_d;
    wpos_q <= wpos_d;
    hops_q <= hops_d;
    phi_q  <= phi_d;
    item_q <= item_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      phase_q   <= PH_HEADER;
      acc_q     <= '0;
      ql_q      <= '0;
      lbl_q     <= '0;
      qstart_q  <= '0;
      qtype_q   <= '0;
      wlen_q    <= '0;
      partial_q <= 1'b0;
      owp_q     <= '0;
      orp_q     <= '0;
      ocnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      ql_q     <= ql_d;
      lbl_q    <= lbl_d;
      qstart_q <= qstart_d;
      qtype_q  <= qtype_d;
      wlen_q   <= wlen_d;
      if (cfg_we_i) begin
        partial_q <= cfg_wdata_i;
      end
      owp_q  <= owp_q + OQ_PTR_W'(push0) + OQ_PTR_W'(push1);
      orp_q  <= orp_q + OQ_PTR_W'(opop);
      ocnt_q <= ocnt_q + (OQ_PTR_W + 1)'(push0) + (OQ_PTR_W + 1)'(push1)
                - (OQ_PTR_W + 1)'(opop);
    end
  end

endmodule

[rtl/core/dns_query_parser_core.sv]
// ----------------------------------------------------------------------------
// DNS query parser core
// Parses the header and question section of a DNS message given byte by byte.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid_i/in_ready_o  data_byte_i, last_byte_i
//  out      output     out_valid_o/out_ready_i record fields, one item each
//  cfg      input      cfg_we_i               cfg_wdata_i (partial mode)
//
// A byte is taken every cycle while the four-entry item queue has room.
// A compression pointer holds the back while it walks the message store,
// through the fetch and check states per label and also the low-byte state per
// pointer hop, so the input stalls once the queue fills.
// The back takes an item only when the result queue has two free entries.
// Reset clears the offset, the parser and both queues; the store is not
// cleared, as only bytes of the current message are ever read.

module dns_query_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  record_kind_o,
  output logic [15:0] word_a_o,
  output logic [15:0] word_b_o,
  output logic [15:0] word_c_o,
  output logic [15:0] word_d_o,
  output logic [15:0] word_e_o,
  output logic        qr_bit_o,
  output logic [3:0]  opcode_o,
  output logic [3:0]  aa_tc_rd_ra_o,
  output logic [2:0]  z_bits_o,
  output logic [3:0]  rcode_o,
  output logic [2:0]  status_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  import dqp_pkg::*;

  item_t push_item, head;
  logic  push, full, pop, head_valid;
  rec_t  rec;

  dqp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  dqp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  dqp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .hd_valid_i  (head_valid),
    .hd_i        (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (rec)
  );

  assign record_kind_o = rec.kind;
  assign word_a_o      = rec.word_a;
  assign word_b_o      = rec.word_b;
  assign word_c_o      = rec.word_c;
  assign word_d_o      = rec.word_d;
  assign word_e_o      = rec.word_e;
  assign qr_bit_o      = rec.qr_bit;
  assign opcode_o      = rec.opcode;
  assign aa_tc_rd_ra_o = rec.aa_tc_rd_ra;
  assign z_bits_o      = rec.z_bits;
  assign rcode_o       = rec.rcode;
  assign status_o      = rec.status;

endmodule

[rtl/core/dqp_checker.sv]
// ----------------------------------------------------------------------------
// DNS query parser checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module dqp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  record_kind_o,
  input logic [15:0] word_a_o,
  input logic [15:0] word_d_o,
  input logic [15:0] word_e_o,
  input logic [2:0]  status_o
);
  import dqp_pkg::*;

  // A waiting item keeps its kind and status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(record_kind_o)
      && $stable(status_o))
    else $error("result item changed while stalled");

  // Kind code three is never produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> record_kind_o != 2'd3)
    else $error("bad record kind");

  // End items carry a known status and empty words A and D.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == KIND_END |->
      status_o <= ST_BAD_PTR_DROPPED && word_a_o == '0 && word_d_o == '0)
    else $error("malformed end item");

  // Only end items carry a status; questions carry no header counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == KIND_QUESTION |->
      status_o == ST_OK && word_d_o == '0 && word_e_o == '0)
    else $error("malformed question item");

endmodule

bind dns_query_parser_core dqp_checker u_dqp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .record_kind_o (record_kind_o),
  .word_a_o      (word_a_o),
  .word_d_o      (word_d_o),
  .word_e_o      (word_e_o),
  .status_o      (status_o)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// DNS query parser core testbench
// Sends DNS messages byte by byte, both well-formed queries and broken ones,
// and checks every record against a predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import dqp_pkg::*;

  // Scoreboard: predicts the records of each accepted byte and checks results.
  class dns_scoreboard;
    typedef enum int {WALK_OK, WALK_BAD_LABEL, WALK_BAD_PTR} walk_e;

    logic [7:0]  msg_store [PACKET_BYTES];
    int unsigned byte_pos;
    int unsigned question_start;
    int unsigned questions_left;
    int unsigned label_left;
    int unsigned field_acc;
    int unsigned qtype;
    int unsigned wire_len;
    phase_e      phase;
    bit          partial;
    rec_t        expected_q[$];
    int          errors;

    function void clear_message();
      byte_pos       = 0;
      phase          = PH_HEADER;
      field_acc      = 0;
      questions_left = 0;
      label_left     = 0;
      question_start = 0;
      qtype          = 0;
      wire_len       = 0;
    endfunction

    function void push_end(status_e st);
      rec_t r;
      r        = '0;
      r.kind   = KIND_END;
      r.status = st;
      expected_q.push_back(r);
      phase = PH_WAIT;
    endfunction

    // Follows a compressed name through the bytes stored so far.
    function walk_e follow_name(int unsigned target);
      int unsigned limit, at, hops, len;
      logic [7:0] b;
      limit = (byte_pos < PACKET_BYTES) ? byte_pos : PACKET_BYTES;
      at    = target;
      hops  = 1;
      forever begin
        if (at >= limit) return WALK_BAD_PTR;
        b = msg_store[at];
        if (b[7:6] == 2'b00) begin
          len = b[5:0];
          if (len == 0) return WALK_OK;
          if (at + 1 + len > limit) return WALK_BAD_PTR;
          at = at + 1 + len;
        end else if (b[7:6] == 2'b11) begin
          if (at + 1 >= limit) return WALK_BAD_PTR;
          hops++;
          if (hops > MAX_POINTER_HOPS) return WALK_BAD_PTR;
          at = {b[5:0], msg_store[at + 1]};
        end else begin
          return WALK_BAD_LABEL;
        end
      end
    endfunction

    // Advances the parser by one accepted byte and queues its records.
    function void note_byte(logic [7:0] b, bit last);
      rec_t  r;
      walk_e w;
      if (byte_pos < PACKET_BYTES) msg_store[byte_pos] = b;
      if (byte_pos < 16'hFFFF) byte_pos++;
      case (phase)
        PH_HEADER: begin
          if (byte_pos == 12) begin
            r             = '0;
            r.kind        = KIND_HEADER;
            r.word_a      = {msg_store[0], msg_store[1]};
            r.word_b      = {msg_store[4], msg_store[5]};
            r.word_c      = {msg_store[6], msg_store[7]};
            r.word_d      = {msg_store[8], msg_store[9]};
            r.word_e      = {msg_store[10], msg_store[11]};
            r.qr_bit      = msg_store[2][7];
            r.opcode      = msg_store[2][6:3];
            r.aa_tc_rd_ra = {msg_store[2][2:0], msg_store[3][7]};
            r.z_bits      = msg_store[3][6:4];
            r.rcode       = msg_store[3][3:0];
            r.status      = ST_OK;
            expected_q.push_back(r);
            if (!r.qr_bit && r.word_b != 0) begin
              questions_left = r.word_b;
              question_start = byte_pos;
              phase          = PH_LHEAD;
            end else begin
              push_end(ST_OK);
            end
          end
        end
        PH_LHEAD: begin
          if (b[7:6] == 2'b00) begin
            if (b[5:0] == 0) begin
              wire_len = (byte_pos - question_start) & 16'hFFFF;
              phase    = PH_QT_HI;
            end else begin
              label_left = b[5:0];
              phase      = PH_LBODY;
            end
          end else if (b[7:6] == 2'b11) begin
            field_acc = b[5:0];
            phase     = PH_PLOW;
          end else begin
            push_end(ST_BAD_LABEL);
          end
        end
        PH_LBODY: begin
          label_left = (label_left - 1) & 63;
          if (label_left == 0) phase = PH_LHEAD;
        end
        PH_PLOW: begin
          w = follow_name({field_acc[5:0], b});
          if (w == WALK_OK) begin
            wire_len = (byte_pos - question_start) & 16'hFFFF;
            phase    = PH_QT_HI;
          end else if (w == WALK_BAD_LABEL) begin
            push_end(ST_BAD_LABEL);
          end else begin
            push_end(partial ? ST_BAD_PTR_KEPT : ST_BAD_PTR_DROPPED);
          end
        end
        PH_QT_HI: begin
          field_acc = b;
          phase     = PH_QT_LO;
        end
        PH_QT_LO: begin
          qtype = {field_acc[7:0], b};
          phase = PH_QC_HI;
        end
        PH_QC_HI: begin
          field_acc = b;
          phase     = PH_QC_LO;
        end
        PH_QC_LO: begin
          r        = '0;
          r.kind   = KIND_QUESTION;
          r.word_a = 16'(qtype);
          r.word_b = {field_acc[7:0], b};
          r.word_c = 16'(wire_len);
          r.status = ST_OK;
          expected_q.push_back(r);
          questions_left = (questions_left - 1) & 16'hFFFF;
          if (questions_left == 0) begin
            push_end(ST_OK);
          end else begin
            question_start = byte_pos;
            phase          = PH_LHEAD;
          end
        end
        default: phase = PH_WAIT;
      endcase
      if (last) begin
        if (phase != PH_WAIT) push_end(partial ? ST_TRUNC_KEPT : ST_TRUNC_DROPPED);
        clear_message();
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Checks one accepted result item against the oldest expected record.
    function void check_rec(rec_t got);
      rec_t e;
      if (expected_q.size() == 0) begin
        $error("record of kind %0d arrived with nothing expected", got.kind);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("record_kind", e.kind, got.kind);
      compare_field("word_a", e.word_a, got.word_a);
      compare_field("word_b", e.word_b, got.word_b);
      compare_field("word_c", e.word_c, got.word_c);
      compare_field("word_d", e.word_d, got.word_d);
      compare_field("word_e", e.word_e, got.word_e);
      compare_field("qr_bit", e.qr_bit, got.qr_bit);
      compare_field("opcode", e.opcode, got.opcode);
      compare_field("aa_tc_rd_ra", e.aa_tc_rd_ra, got.aa_tc_rd_ra);
      compare_field("z_bits", e.z_bits, got.z_bits);
      compare_field("rcode", e.rcode, got.rcode);
      compare_field("status", e.status, got.status);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  record_kind;
  logic [15:0] word_a, word_b, word_c, word_d, word_e;
  logic        qr_bit;
  logic [3:0]  opcode, aa_tc_rd_ra, rcode;
  logic [2:0]  z_bits, status;
  logic        cfg_we;
  logic        cfg_wdata;

  dns_scoreboard sb;
  logic [7:0]    msg[$];
  bit            send_burst;

  dns_query_parser_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte),
    .last_byte_i  (last_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .record_kind_o(record_kind),
    .word_a_o     (word_a),
    .word_b_o     (word_b),
    .word_c_o     (word_c),
    .word_d_o     (word_d),
    .word_e_o     (word_e),
    .qr_bit_o     (qr_bit),
    .opcode_o     (opcode),
    .aa_tc_rd_ra_o(aa_tc_rd_ra),
    .z_bits_o     (z_bits),
    .rcode_o      (rcode),
    .status_o     (status),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sends one byte, with a random gap before it unless in a burst.
  task automatic send_byte(logic [7:0] b, bit last);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk_i); while (!in_ready);
    sb.note_byte(b, last);
  endtask

  // Sends the built message, the final byte marked as last.
  task automatic send_message();
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    if ($urandom_range(0, 7) == 0) send_burst = ~send_burst;
  endtask

  // Waits until the block is idle, then writes the mode register.
  task automatic write_mode(bit mode);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.partial = mode;
  endtask

  task automatic add_header(logic [15:0] flags, logic [15:0] qd);
    msg.push_back(8'($urandom_range(0, 255)));
    msg.push_back(8'($urandom_range(0, 255)));
    msg.push_back(flags[15:8]);
    msg.push_back(flags[7:0]);
    msg.push_back(qd[15:8]);
    msg.push_back(qd[7:0]);
    repeat (6) msg.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_label(int len);
    msg.push_back(8'(len));
    repeat (len) msg.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_pointer(int target);
    msg.push_back(8'hC0 | {2'b00, target[13:8]});
    msg.push_back(target[7:0]);
  endtask

  task automatic add_type_class();
    repeat (4) msg.push_back(8'($urandom_range(0, 255)));
  endtask

  // Builds a random name: labels, a pointer back to the first name, or both.
  task automatic add_name(int first_name);
    int style, n;
    style = $urandom_range(0, 3);
    if (style != 3 || first_name < 0) begin
      n = $urandom_range(0, 3);
      repeat (n) add_label($urandom_range(0, 9) == 0 ? 63 : $urandom_range(1, 8));
    end
    if (style >= 2 && first_name >= 0) add_pointer(first_name);
    else msg.push_back(8'h00);
  endtask

  // Builds a random message: mostly well-formed queries, some broken.
  task automatic build_random();
    int kind, nq, first_name, at;
    logic [15:0] flags;
    msg.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 40)) msg.push_back(8'($urandom_range(0, 255)));
      return;
    end
    flags     = 16'($urandom_range(0, 16'hFFFF));
    flags[15] = (kind < 16);
    nq        = $urandom_range(1, 3);
    add_header(flags, 16'(($urandom_range(0, 9) == 0) ? nq + 1 : nq));
    first_name = -1;
    for (int q = 0; q < nq; q++) begin
      at = msg.size();
      add_name(first_name);
      if (first_name < 0) first_name = at;
      add_type_class();
    end
    if (kind >= 16 && kind < 26) begin
      // Corrupt a name byte with a reserved label type.
      msg[12] = 8'(($urandom_range(0, 1) ? 8'h40 : 8'h80) | $urandom_range(0, 63));
    end else if (kind >= 26 && kind < 34) begin
      // Pointer beyond the stored bytes, into the header, or onto itself.
      msg = msg[0:11];
      case ($urandom_range(0, 2))
        0: add_pointer($urandom_range(14, 16'h3FFF));
        1: add_pointer($urandom_range(0, 11));
        default: add_pointer(12);
      endcase
      add_type_class();
    end
    if ($urandom_range(0, 6) == 0) msg = msg[0:$urandom_range(0, msg.size() - 1)];
    else if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom_range(0, 255)));
  endtask

  // Directed messages: header extremes, every status of the dropped mode and the long message.
  task automatic run_directed();
    msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message();
    msg = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_message();
    msg = '{8'hAA};
    send_message();
    msg.delete(); add_header(16'h0100, 16'd1); add_label(63); msg.push_back(8'h00);
    add_type_class(); add_pointer(12); send_message();
    msg.delete(); add_header(16'h0100, 16'd2); add_label(3); msg.push_back(8'h00);
    add_type_class(); add_pointer(12); add_type_class(); send_message();
    msg.delete(); add_header(16'h0100, 16'd1); msg.push_back(8'h41); send_message();
    msg.delete(); add_header(16'h0100, 16'd1); msg.push_back(8'h80); send_message();
    msg.delete(); add_header(16'h0100, 16'd1); add_pointer(16'h3FFF); add_type_class();
    send_message();
    msg.delete(); add_header(16'h0100, 16'd1); add_pointer(12); add_type_class();
    send_message();
    msg.delete(); add_header(16'h0100, 16'd1); add_label(5); send_message();
    // A name that runs past the end of the store.
    msg.delete(); add_header(16'h0000, 16'd2);
    repeat (9) add_label(63);
    msg.push_back(8'h00); add_type_class(); add_pointer(12); add_type_class();
    send_message();
  endtask

  // Receiver with random stalls and one long hold that backs up the block.
  initial begin
    int stall, count;
    bit burst;
    out_ready <= 1'b0;
    count = 0;
    burst = 0;
    @(posedge rst_ni);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 17);
      if (count == 300) stall = 500;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      sb.check_rec('{kind: kind_e'(record_kind), word_a: word_a, word_b: word_b,
                     word_c: word_c, word_d: word_d, word_e: word_e,
                     qr_bit: qr_bit, opcode: opcode, aa_tc_rd_ra: aa_tc_rd_ra,
                     z_bits: z_bits, rcode: rcode, status: status_e'(status)});
      count++;
      if (count % 50 == 0) burst = ~burst;
    end
  end

  // Main sequence: reset, directed part, then random phases in both modes.
  initial begin
    int sent;
    sb = new();
    sb.clear_message();
    sb.partial    = 0;
    send_burst    = 0;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    sent = 0;
    for (int p = 0; p < 4; p++) begin
      write_mode(p[0]);
      while (sent < (p + 1) * 235) begin
        build_random();
        sent += msg.size();
        send_message();
      end
    end
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS dns_query_parser_core");
    else $display("FAIL dns_query_parser_core");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL dns_query_parser_core");
    $finish;
  end

endmodule
